FILE: rtl/srfp_pkg.sv
// Shared types and constants for the serial response frame parser.
// No dependencies; imported by srfp_core and serial_response_frame_parser.
package srfp_pkg;

    // Frame delimiters and length rules
    localparam logic [7:0] START_BYTE = 8'h55;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'hAA;
    localparam logic [7:0] MIN_LEN    = 8'd9;
    localparam logic [7:0] HDR_LEN    = 8'd8;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_ZERO1 = 4'd1,
        PH_LEN   = 4'd2,
        PH_TYPE  = 4'd3,
        PH_ADDR  = 4'd4,
        PH_DATA  = 4'd5,
        PH_CHECK = 4'd6,
        PH_ZERO2 = 4'd7,
        PH_END   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_DATA  = 3'd0,
        EV_DONE  = 3'd1,
        EV_CSUM  = 3'd2,
        EV_TRAIL = 3'd3,
        EV_LEN   = 3'd4
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] frame_kind;
        logic [7:0] frame_address;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] payload_count;
    } result_t;

endpackage

FILE: rtl/srfp_core.sv
// Deframing state machine: consumes one byte per step, produces at most one result.
// Depends on srfp_pkg.
module srfp_core
    import srfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] kind_reg, kind_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;

    logic [8:0] count_plus_min;
    logic [7:0] sum_add;

    assign count_plus_min = {1'b0, count_reg} + {1'b0, MIN_LEN};
    assign sum_add        = sum_reg + rx_byte;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        kind_next    = kind_reg;
        address_next = address_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == START_BYTE)
                    phase_next = PH_ZERO1;
            end
            PH_ZERO1:
            begin
                if (rx_byte == ZERO_BYTE)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                kind_next    = '0;
                address_next = '0;
                if (rx_byte < MIN_LEN)
                begin
                    phase_next  = PH_HUNT;
                    length_next = '0;
                    count_next  = '0;
                    sum_next    = '0;
                end
                else
                begin
                    length_next = rx_byte;
                    sum_next    = rx_byte;
                    phase_next  = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                kind_next  = rx_byte;
                sum_next   = sum_add;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                address_next = rx_byte;
                sum_next     = sum_add;
                count_next   = '0;
                phase_next   = PH_DATA;
            end
            PH_DATA:
            begin
                sum_next = sum_add;
                if (count_plus_min >= {1'b0, length_reg})
                    phase_next = PH_CHECK;
                else
                    count_next = count_reg + 8'd1;
            end
            PH_CHECK, PH_ZERO2, PH_END:
            begin
                if ((phase_reg == PH_CHECK && rx_byte == ~sum_reg) ||
                    (phase_reg == PH_ZERO2 && rx_byte == ZERO_BYTE))
                begin
                    phase_next = (phase_reg == PH_CHECK) ? PH_ZERO2 : PH_END;
                end
                else if (phase_reg == PH_END && rx_byte == END_BYTE)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    // abandon the frame; kind is kept until the next LEN
                    phase_next   = PH_HUNT;
                    length_next  = '0;
                    address_next = '0;
                    count_next   = '0;
                    sum_next     = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        res_valid         = 1'b0;
        res.event_res     = EV_DATA;
        res.frame_kind    = kind_reg;
        res.frame_address = address_reg;
        res.payload_byte  = '0;
        res.payload_index = '0;
        res.payload_count = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                res.frame_kind    = '0;
                res.frame_address = '0;
                if (rx_byte < MIN_LEN)
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_LEN;
                end
            end
            PH_DATA:
            begin
                res_valid         = 1'b1;
                res.event_res     = EV_DATA;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
            end
            PH_CHECK:
            begin
                if (rx_byte != ~sum_reg)
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_CSUM;
                end
            end
            PH_ZERO2:
            begin
                if (rx_byte != ZERO_BYTE)
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_TRAIL;
                end
            end
            PH_END:
            begin
                res_valid = 1'b1;
                if (rx_byte == END_BYTE)
                begin
                    res.event_res     = EV_DONE;
                    res.payload_count = length_reg - HDR_LEN;
                end
                else
                    res.event_res = EV_TRAIL;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            length_reg  <= '0;
            kind_reg    <= '0;
            address_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            kind_reg    <= kind_next;
            address_reg <= address_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

FILE: rtl/serial_response_frame_parser.sv
// Top level of the serial response frame parser: byte handshake, deframer, output skid.
// Depends on srfp_pkg and srfp_core.
//
// Accepts one received UART byte per beat and deframes 0x55 0x00 LEN TYPE ADDR
// DATA[LEN-8] CHECK 0x00 0xAA. Each data byte comes out as an event-0 beat with
// its payload index; the closing 0xAA gives an event-1 beat with the payload
// count. Checksum (2), trailer (3) and short-length (4) errors send the parser
// back to hunting for 0x55. Bytes that cause no event produce no output beat.
// Throughput is one byte per clock while in_ready is high: the frame state updates in
// the cycle a byte is accepted and any result is registered on the same edge, into the
// output or skid register. A two-entry output buffer (output register
// plus skid register) keeps in_ready high while one result waits; in_ready
// drops only when both entries hold results.
module serial_response_frame_parser
    import srfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] frame_kind,
    output logic [7:0] frame_address,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] payload_count
);

    logic    in_beat;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    out_free;

    // Skid register empty means there is always room for one more result.
    assign in_ready = !skid_valid_reg;
    assign in_beat  = in_valid && in_ready;

    srfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_beat),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register can load this cycle when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                if (skid_valid_reg)
                    out_valid_reg <= 1'b1;
                else
                    out_valid_reg <= in_beat && res_valid;
            end
            // skid fills only when output is stalled; drains into output when free
            if (skid_valid_reg)
                skid_valid_reg <= !out_free;
            else
                skid_valid_reg <= in_beat && res_valid && !out_free;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_beat && res_valid)
                out_reg <= res;
        end
        if (!skid_valid_reg && in_beat && res_valid && !out_free)
            skid_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.event_res;
    assign frame_kind    = out_reg.frame_kind;
    assign frame_address = out_reg.frame_address;
    assign payload_byte  = out_reg.payload_byte;
    assign payload_index = out_reg.payload_index;
    assign payload_count = out_reg.payload_count;

endmodule
